[rtl/cmcs_pkg.sv]
// package for the compressed mip chain size block
// holds field widths, format codes, scaling codes and the ceiling-divide helpers
// no dependencies
`default_nettype none

package cmcs_pkg;

  localparam int DIM_W   = 15;
  localparam int LVLIN_W = 4;
  localparam int LV_W    = 5;
  localparam int FMT_W   = 4;
  localparam int TOTAL_W = 31;
  localparam int PROD_W  = 2 * DIM_W;
  localparam int LVLB_W  = 33;
  localparam int SUM_W   = 34;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 31'h7FFF_FFFF;

  // format codes
  localparam logic [FMT_W-1:0] FMT_RAW      = 4'd0;
  localparam logic [FMT_W-1:0] FMT_ASTC4    = 4'd1;
  localparam logic [FMT_W-1:0] FMT_ASTC5    = 4'd2;
  localparam logic [FMT_W-1:0] FMT_ASTC6    = 4'd3;
  localparam logic [FMT_W-1:0] FMT_ASTC8    = 4'd4;
  localparam logic [FMT_W-1:0] FMT_ETC2RGBA = 4'd5;
  localparam logic [FMT_W-1:0] FMT_ETC2RGB  = 4'd6;
  localparam logic [FMT_W-1:0] FMT_PVRTC4   = 4'd7;
  localparam logic [FMT_W-1:0] FMT_PVRTC2   = 4'd8;
  localparam logic [FMT_W-1:0] FMT_DXT5     = 4'd9;
  localparam logic [FMT_W-1:0] FMT_DXT1     = 4'd10;

  // reciprocal multipliers for ceiling divide by 5 and 6
  localparam int RECIP_W  = 18;
  localparam int RECIP_SH = 20;
  localparam int RPROD_W  = DIM_W + 1 + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP5 = 18'd209716;
  localparam logic [RECIP_W-1:0] RECIP6 = 18'd174763;

  // how a level's product is scaled into bytes
  typedef enum logic [2:0] {
    SC_RAW,
    SC_B16,
    SC_B8,
    SC_P4,
    SC_P2
  } scale_t;

  typedef struct packed {
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [LV_W-1:0]    lv;
    logic [FMT_W-1:0]   fmt;
    logic [TOTAL_W-1:0] total;
  } ctx_t;

  function automatic logic [DIM_W-1:0] ceil_div5(input logic [DIM_W-1:0] v);
    logic [DIM_W:0]     s;
    logic [RPROD_W-1:0] p;
    s = {1'b0, v} + (DIM_W+1)'(4);
    p = RPROD_W'(s) * RPROD_W'(RECIP5);
    return {1'b0, p[RECIP_SH +: DIM_W-1]};
  endfunction

  function automatic logic [DIM_W-1:0] ceil_div6(input logic [DIM_W-1:0] v);
    logic [DIM_W:0]     s;
    logic [RPROD_W-1:0] p;
    s = {1'b0, v} + (DIM_W+1)'(5);
    p = RPROD_W'(s) * RPROD_W'(RECIP6);
    return {1'b0, p[RECIP_SH +: DIM_W-1]};
  endfunction

  function automatic logic [DIM_W-1:0] ceil_div4(input logic [DIM_W-1:0] v);
    logic [DIM_W:0] s;
    s = {1'b0, v} + (DIM_W+1)'(3);
    return {1'b0, s[2 +: DIM_W-1]};
  endfunction

  function automatic logic [DIM_W-1:0] ceil_div8(input logic [DIM_W-1:0] v);
    logic [DIM_W:0] s;
    s = {1'b0, v} + (DIM_W+1)'(7);
    return {2'b0, s[3 +: DIM_W-2]};
  endfunction

  function automatic logic [DIM_W-1:0] at_least(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lo);
    return (v < lo) ? lo : v;
  endfunction

endpackage

`default_nettype wire

[rtl/compressed_mip_chain_size_core.sv]
// top level of the compressed mip chain size block
// one three-stage slice per mip level: block grid, product, accumulate
// depends on cmcs_pkg
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | tex_width, tex_height, level_count, format_code
//   rsp     | out       | rsp_valid, rsp_stall | total_bytes
//
// a transaction enters every cycle unless a stalled rsp holds the pipeline; an input register leads the slices
// each level slice has a grid stage, a multiply stage and an accumulate stage
// rst is synchronous and clears the valid bits only
// a stalled rsp with rsp_valid high freezes the whole pipeline and raises req_stall in that cycle
`default_nettype none

module compressed_mip_chain_size_core
  import cmcs_pkg::*;
#(
  parameter int MAX_LEVELS = 15,
  parameter int MAX_DIM    = 16384
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic [DIM_W-1:0]   tex_width,
  input  wire logic [DIM_W-1:0]   tex_height,
  input  wire logic [LVLIN_W-1:0] level_count,
  input  wire logic [FMT_W-1:0]   format_code,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output logic [TOTAL_W-1:0]      total_bytes
);

  logic adv;

  logic [MAX_LEVELS:0] ctx_v;
  ctx_t                ctx [MAX_LEVELS+1];

  logic [MAX_LEVELS-1:0] a_v;
  ctx_t                  a_ctx [MAX_LEVELS];
  logic [DIM_W-1:0]      a_cx  [MAX_LEVELS];
  logic [DIM_W-1:0]      a_cy  [MAX_LEVELS];
  scale_t                a_sc  [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] a_act;

  logic [MAX_LEVELS-1:0] b_v;
  ctx_t                  b_ctx  [MAX_LEVELS];
  logic [PROD_W-1:0]     b_prod [MAX_LEVELS];
  scale_t                b_sc   [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] b_act;

  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;
  assign rsp_valid = ctx_v[MAX_LEVELS];
  assign total_bytes = ctx[MAX_LEVELS].total;

  // input clamp stage
  ctx_t in_ctx;
  always_comb begin
    in_ctx.w = tex_width;
    if (tex_width == '0) begin
      in_ctx.w = DIM_W'(1);
    end else if (tex_width > DIM_W'(MAX_DIM)) begin
      in_ctx.w = DIM_W'(MAX_DIM);
    end
    in_ctx.h = tex_height;
    if (tex_height == '0) begin
      in_ctx.h = DIM_W'(1);
    end else if (tex_height > DIM_W'(MAX_DIM)) begin
      in_ctx.h = DIM_W'(MAX_DIM);
    end
    in_ctx.lv = LV_W'(level_count);
    if (LV_W'(level_count) > LV_W'(MAX_LEVELS)) begin
      in_ctx.lv = LV_W'(MAX_LEVELS);
    end
    in_ctx.fmt   = format_code;
    in_ctx.total = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_v[0] <= 1'b0;
    end else if (adv) begin
      ctx_v[0] <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx[0] <= in_ctx;
    end
  end

  for (genvar gl = 0; gl < MAX_LEVELS; gl++) begin : g_level
    logic [DIM_W-1:0] cx;
    logic [DIM_W-1:0] cy;
    scale_t           sc;
    ctx_t             nxt;
    logic [LVLB_W-1:0] lvl_bytes;
    logic [SUM_W-1:0]  sum;
    ctx_t              acc;

    // block grid and next level dimensions
    always_comb begin
      cx = ctx[gl].w;
      cy = ctx[gl].h;
      sc = SC_RAW;
      case (ctx[gl].fmt) inside
        FMT_ASTC4, FMT_ETC2RGBA, FMT_DXT5: begin
          cx = ceil_div4(ctx[gl].w);
          cy = ceil_div4(ctx[gl].h);
          sc = SC_B16;
        end
        FMT_ETC2RGB, FMT_DXT1: begin
          cx = ceil_div4(ctx[gl].w);
          cy = ceil_div4(ctx[gl].h);
          sc = SC_B8;
        end
        FMT_ASTC5: begin
          cx = ceil_div5(ctx[gl].w);
          cy = ceil_div5(ctx[gl].h);
          sc = SC_B16;
        end
        FMT_ASTC6: begin
          cx = ceil_div6(ctx[gl].w);
          cy = ceil_div6(ctx[gl].h);
          sc = SC_B16;
        end
        FMT_ASTC8: begin
          cx = ceil_div8(ctx[gl].w);
          cy = ceil_div8(ctx[gl].h);
          sc = SC_B16;
        end
        FMT_PVRTC4: begin
          cx = at_least(ctx[gl].w, DIM_W'(8));
          cy = at_least(ctx[gl].h, DIM_W'(8));
          sc = SC_P4;
        end
        FMT_PVRTC2: begin
          cx = at_least(ctx[gl].w, DIM_W'(16));
          cy = at_least(ctx[gl].h, DIM_W'(8));
          sc = SC_P2;
        end
        default: begin
          cx = ctx[gl].w;
          cy = ctx[gl].h;
          sc = SC_RAW;
        end
      endcase
      nxt   = ctx[gl];
      nxt.w = at_least(ctx[gl].w >> 1, DIM_W'(1));
      nxt.h = at_least(ctx[gl].h >> 1, DIM_W'(1));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v[gl] <= 1'b0;
        b_v[gl] <= 1'b0;
        ctx_v[gl+1] <= 1'b0;
      end else if (adv) begin
        a_v[gl] <= ctx_v[gl];
        b_v[gl] <= a_v[gl];
        ctx_v[gl+1] <= b_v[gl];
      end
    end

    // scale product into bytes, zero it past the level count and accumulate with saturation
    always_comb begin
      case (b_sc[gl])
        SC_B16:  lvl_bytes = LVLB_W'(b_prod[gl]) << 4;
        SC_B8:   lvl_bytes = LVLB_W'(b_prod[gl]) << 3;
        SC_P4:   lvl_bytes = LVLB_W'(b_prod[gl]) >> 1;
        SC_P2:   lvl_bytes = LVLB_W'(b_prod[gl]) >> 2;
        default: lvl_bytes = LVLB_W'(b_prod[gl]) << 2;
      endcase
      if (!b_act[gl]) begin
        lvl_bytes = '0;
      end
      sum = SUM_W'(b_ctx[gl].total) + SUM_W'(lvl_bytes);
      acc = b_ctx[gl];
      acc.total = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_ctx[gl] <= nxt;
        a_cx[gl]  <= cx;
        a_cy[gl]  <= cy;
        a_sc[gl]  <= sc;
        a_act[gl] <= (ctx[gl].lv > LV_W'(gl));
        b_ctx[gl]  <= a_ctx[gl];
        b_prod[gl] <= PROD_W'(a_cx[gl]) * PROD_W'(a_cy[gl]);
        b_sc[gl]   <= a_sc[gl];
        b_act[gl]  <= a_act[gl];
        ctx[gl+1]  <= acc;
      end
    end
  end

endmodule

`default_nettype wire

[test/compressed_mip_chain_size_checker.sv]
// checker for the compressed mip chain size block: watches both channels,
// predicts the total byte size of each requested mip chain and compares it
// depends on cmcs_pkg
`timescale 1ns / 100ps

module compressed_mip_chain_size_checker
  import cmcs_pkg::*;
#(
  parameter int MAX_LEVELS = 15,
  parameter int MAX_DIM    = 16384
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire logic               req_stall,
  input  wire logic [DIM_W-1:0]   tex_width,
  input  wire logic [DIM_W-1:0]   tex_height,
  input  wire logic [LVLIN_W-1:0] level_count,
  input  wire logic [FMT_W-1:0]   format_code,
  input  wire logic               rsp_valid,
  input  wire logic               rsp_stall,
  input  wire logic [TOTAL_W-1:0] total_bytes,
  output int                      failures,
  output int                      pending
);

  logic [TOTAL_W-1:0] chain_totals_due[$];
  int                 mismatch_count = 0;

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic logic [TOTAL_W-1:0] mip_chain_bytes(input logic [DIM_W-1:0]   w_in,
                                                         input logic [DIM_W-1:0]   h_in,
                                                         input logic [LVLIN_W-1:0] lc,
                                                         input logic [FMT_W-1:0]   fmt);
    longint unsigned w, h, sum, lvl, bw, bh, bb;
    int              n;
    w = (w_in == 0) ? 1 : ((w_in > MAX_DIM) ? MAX_DIM : w_in);
    h = (h_in == 0) ? 1 : ((h_in > MAX_DIM) ? MAX_DIM : h_in);
    n = (lc > MAX_LEVELS) ? MAX_LEVELS : lc;
    sum = 0;
    bw = 0;
    bh = 0;
    bb = 0;
    case (fmt)
      FMT_ASTC4, FMT_ETC2RGBA, FMT_DXT5: begin
        bw = 4; bh = 4; bb = 16;
      end
      FMT_ASTC5: begin
        bw = 5; bh = 5; bb = 16;
      end
      FMT_ASTC6: begin
        bw = 6; bh = 6; bb = 16;
      end
      FMT_ASTC8: begin
        bw = 8; bh = 8; bb = 16;
      end
      FMT_ETC2RGB, FMT_DXT1: begin
        bw = 4; bh = 4; bb = 8;
      end
      default: bw = 0;
    endcase
    for (int i = 0; i < n; i++) begin
      if (fmt == FMT_PVRTC4)
        lvl = ((w < 8 ? 8 : w) * (h < 8 ? 8 : h) * 4) / 8;
      else if (fmt == FMT_PVRTC2)
        lvl = ((w < 16 ? 16 : w) * (h < 8 ? 8 : h) * 2) / 8;
      else if (bw != 0)
        lvl = ((w + bw - 1) / bw) * ((h + bh - 1) / bh) * bb;
      else
        lvl = w * h * 4;
      sum += lvl;
      if (sum > TOTAL_MAX)
        sum = TOTAL_MAX;
      w = (w / 2 < 1) ? 1 : w / 2;
      h = (h / 2 < 1) ? 1 : h / 2;
    end
    return sum[TOTAL_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [TOTAL_W-1:0] due;
    if (!rst) begin
      if (req_valid && !req_stall)
        chain_totals_due = {chain_totals_due,
                            mip_chain_bytes(tex_width, tex_height,
                                            level_count, format_code)};
      if (rsp_valid && !rsp_stall) begin
        if (chain_totals_due.size() == 0) begin
          $error("total_bytes: result %0d with no request outstanding", total_bytes);
          mismatch_count++;
        end else begin
          due = chain_totals_due.pop_front();
          if (total_bytes !== due) begin
            $error("total_bytes mismatch: expected %0d, actual %0d", due, total_bytes);
            mismatch_count++;
          end
        end
      end
    end
    failures <= mismatch_count;
    pending  <= chain_totals_due.size();
  end

endmodule

[test/tb_compressed_mip_chain_size_core.sv]
// testbench top for compressed_mip_chain_size_core: drives size requests with
// random idling and result stalls, and reports the checker's verdict
// depends on cmcs_pkg, compressed_mip_chain_size_core and compressed_mip_chain_size_checker
`timescale 1ns / 100ps

module tb_compressed_mip_chain_size_core
  import cmcs_pkg::*;
();

  localparam int MAX_LEVELS   = 15;
  localparam int MAX_DIM      = 16384;
  localparam int LATENCY      = 1 + 3 * MAX_LEVELS;
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 200000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [DIM_W-1:0]   tex_width = '0;
  logic [DIM_W-1:0]   tex_height = '0;
  logic [LVLIN_W-1:0] level_count = '0;
  logic [FMT_W-1:0]   format_code = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [TOTAL_W-1:0] total_bytes;

  int  failures;
  int  pending;
  int  cycle_count = 0;
  int  requests_sent = 0;
  bit  req_idle_en = 1'b1;
  bit  rsp_stall_en = 1'b1;

  compressed_mip_chain_size_core #(
    .MAX_LEVELS(MAX_LEVELS),
    .MAX_DIM   (MAX_DIM)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .tex_width  (tex_width),
    .tex_height (tex_height),
    .level_count(level_count),
    .format_code(format_code),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .total_bytes(total_bytes)
  );

  compressed_mip_chain_size_checker #(
    .MAX_LEVELS(MAX_LEVELS),
    .MAX_DIM   (MAX_DIM)
  ) chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .tex_width  (tex_width),
    .tex_height (tex_height),
    .level_count(level_count),
    .format_code(format_code),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .total_bytes(total_bytes),
    .failures   (failures),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst)
      rsp_stall <= 1'b0;
    else
      rsp_stall <= rsp_stall_en && ($urandom_range(99) < 11);
  end

  task automatic send_request(input logic [DIM_W-1:0]   w,
                              input logic [DIM_W-1:0]   h,
                              input logic [LVLIN_W-1:0] lc,
                              input logic [FMT_W-1:0]   fmt);
    while (req_idle_en && ($urandom_range(99) < 11)) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    tex_width   <= w;
    tex_height  <= h;
    level_count <= lc;
    format_code <= fmt;
    do
      @(posedge clk);
    while (req_stall);
    requests_sent++;
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
  endtask

  function automatic logic [DIM_W-1:0] random_dim();
    case ($urandom_range(9))
      0, 1, 2, 3: return DIM_W'($urandom_range(MAX_DIM, 1));
      4, 5:       return DIM_W'($urandom_range(64, 1));
      6:          return DIM_W'($urandom_range(MAX_DIM, MAX_DIM - 400));
      7:          return DIM_W'($urandom_range(32767, MAX_DIM + 1));
      8:          return DIM_W'(1 << $urandom_range(14));
      default:    return ($urandom_range(3) == 0) ? '0 : DIM_W'($urandom_range(32767));
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every format code once, with varied sizes to exercise grid rounding
    for (int f = 0; f < 16; f++)
      send_request(DIM_W'(37 + 13 * f), DIM_W'(19 + 7 * f), 4'd15, FMT_W'(f));
    // dimension and level extremes
    send_request('0, '0, 4'd15, FMT_RAW);
    send_request('1, '1, 4'd15, FMT_RAW);
    send_request(DIM_W'(MAX_DIM), DIM_W'(MAX_DIM), 4'd15, FMT_RAW);
    send_request(DIM_W'(MAX_DIM + 1), DIM_W'(3), 4'd1, FMT_ASTC5);
    send_request(DIM_W'(MAX_DIM), DIM_W'(1), 4'd15, FMT_PVRTC4);
    send_request(DIM_W'(1), DIM_W'(MAX_DIM), 4'd15, FMT_PVRTC2);
    send_request(DIM_W'(1), DIM_W'(1), 4'd0, FMT_DXT1);
    send_request(DIM_W'(5), DIM_W'(7), 4'd15, FMT_ASTC6);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      req_idle_en  = !(i >= 200 && i < 350);
      rsp_stall_en = !(i >= 200 && i < 350);
      if (i == 450)
        drain_results();
      send_request(random_dim(), random_dim(), LVLIN_W'($urandom_range(15)),
                   FMT_W'($urandom_range(15)));
    end
    rsp_stall_en = 1'b1;
    drain_results();
    repeat (2 * LATENCY) @(posedge clk);

    $display("sent %0d size requests: all format codes, zero to fifteen levels,", requests_sent);
    $display("dimensions from zero to beyond the maximum, with idling and result stalls");
    if (failures == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
